### hw/rtl/rpc_pkg.sv
// Package for the range peak counter: sizes, request codes and the
// control/status structs passed between the sequencer and the store units.
// No dependencies.
`default_nettype none

package rpc_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int AW         = $clog2(MAX_LENGTH);
  localparam int KW         = AW + 2;
  localparam int CLR_W      = AW + 1;

  localparam int LEN_W = 11;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  localparam int WIN = 5;

  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic            start;
    logic            add;
    logic            neg;
    logic [KW-1:0]   k;
  } tree_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic             idle;
    logic             done;
    logic [CNT_W-1:0] sum;
  } tree_sts_t;

  typedef struct packed {
    logic                    start;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        len;
  } val_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       idle;
    logic       done;
    logic [2:0] chg;
    logic [2:0] up;
  } val_sts_t;

endpackage

`default_nettype wire

### hw/rtl/rpc_req_if.sv
// Request channel of the range peak counter: valid/ready and one request word.
// Depends on rpc_pkg.
`default_nettype none

interface rpc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [rpc_pkg::IDX_W-1:0]        range_low;
  logic [rpc_pkg::IDX_W-1:0]        range_high;
  logic [rpc_pkg::IDX_W-1:0]        update_index;
  logic signed [rpc_pkg::VAL_W-1:0] update_value;

  modport source (
    output valid, req_type, range_low, range_high, update_index, update_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, range_low, range_high, update_index, update_value,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/rpc_rsp_if.sv
// Response channel of the range peak counter: valid/ready and one result word.
// Depends on rpc_pkg.
`default_nettype none

interface rpc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rpc_pkg::CNT_W-1:0] peak_count;
  logic                      bad_request;

  modport source (
    output valid, peak_count, bad_request,
    input  ready
  );

  modport sink (
    input  valid, peak_count, bad_request,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/rpc_values.sv
// Value/flag store: one memory of {peak flag, value} words, a five-entry read
// window and the flag recompute for one update. Depends on rpc_pkg.
`default_nettype none

module rpc_values (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpc_pkg::val_cmd_t cmd_i,
  output rpc_pkg::val_sts_t sts_o
);
  import rpc_pkg::*;

  localparam logic [1:0] V_IDLE = 2'd0;
  localparam logic [1:0] V_RD   = 2'd1;
  localparam logic [1:0] V_WB   = 2'd2;

  logic [VAL_W:0] mem [MAX_LENGTH];
  logic [VAL_W:0] rdata_q;

  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [VAL_W:0]          mem_wd;
  logic                    mem_re;
  logic [AW-1:0]           mem_ra;

  logic [1:0]              state_q, state_d;
  logic [CLR_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic                    clr_done;
  logic [2:0]              w_q, w_d;
  logic                    pend_q, pend_d;
  logic [2:0]              pend_w_q, pend_w_d;
  logic [1:0]              s_q, s_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic signed [VAL_W-1:0] win_val_q [WIN];
  logic                    win_flg_q [WIN];
  logic                    win_shift;
  logic                    win_load;
  logic signed [VAL_W-1:0] win_in_val;
  logic                    win_in_flg;
  logic [2:0]              chg_q, chg_d;
  logic [2:0]              up_q, up_d;
  logic                    done_q, done_d;

  logic [KW-1:0]           pos;
  logic                    pos_ok;
  logic                    new_flg;

  assign clr_done = (clr_cnt_q == CLR_W'(MAX_LENGTH));

  assign pos     = KW'(idx_q) + KW'(s_q);
  assign pos_ok  = (pos >= KW'(2)) && (pos + KW'(1) <= KW'(len_q));
  assign new_flg = (win_val_q[1] > win_val_q[0]) && (win_val_q[1] > win_val_q[2]);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    w_d        = w_q;
    pend_d     = 1'b0;
    pend_w_d   = pend_w_q;
    s_d        = s_q;
    idx_d      = idx_q;
    val_d      = val_q;
    len_d      = len_q;
    chg_d      = chg_q;
    up_d       = up_q;
    done_d     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    win_shift  = 1'b0;
    win_load   = 1'b0;
    win_in_val = rdata_q[VAL_W-1:0];
    win_in_flg = rdata_q[VAL_W];

    if (!clr_done) begin
      mem_we    = 1'b1;
      mem_wa    = clr_cnt_q[AW-1:0];
      clr_cnt_d = clr_cnt_q + CLR_W'(1);
    end

    case (state_q)
      V_IDLE: begin
        if (cmd_i.start) begin
          idx_d   = cmd_i.idx;
          val_d   = cmd_i.value;
          len_d   = cmd_i.len;
          w_d     = '0;
          state_d = V_RD;
        end
      end
      V_RD: begin
        if (pend_q) begin
          win_load = 1'b1;
          if (pend_w_q == 3'd2) begin
            win_in_val = val_q;
          end
        end
        if (w_q < 3'(WIN)) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(idx_q) + AW'(w_q) - AW'(2);
          pend_d   = 1'b1;
          pend_w_d = w_q;
          w_d      = w_q + 3'd1;
        end else begin
          s_d     = '0;
          state_d = V_WB;
        end
      end
      V_WB: begin
        win_shift = 1'b1;
        chg_d     = {pos_ok && (new_flg != win_flg_q[1]), chg_q[2:1]};
        up_d      = {new_flg, up_q[2:1]};
        if (pos_ok) begin
          mem_we = 1'b1;
          mem_wa = pos[AW-1:0] - AW'(1);
          mem_wd = {new_flg, win_val_q[1]};
        end else if (s_q == 2'd1) begin
          mem_we = 1'b1;
          mem_wa = AW'(idx_q);
          mem_wd = {win_flg_q[1], win_val_q[1]};
        end
        if (s_q == 2'd2) begin
          done_d  = 1'b1;
          state_d = V_IDLE;
        end else begin
          s_d = s_q + 2'd1;
        end
      end
      default: begin
        state_d = V_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_load || win_shift) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win_val_q[i] <= win_val_q[i+1];
        win_flg_q[i] <= win_flg_q[i+1];
      end
      win_val_q[WIN-1] <= win_in_val;
      win_flg_q[WIN-1] <= win_in_flg;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    len_q    <= len_d;
    pend_w_q <= pend_w_d;
    chg_q    <= chg_d;
    up_q     <= up_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= V_IDLE;
      clr_cnt_q <= '0;
      w_q       <= '0;
      pend_q    <= 1'b0;
      s_q       <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      w_q       <= w_d;
      pend_q    <= pend_d;
      s_q       <= s_d;
      done_q    <= done_d;
    end
  end

  assign sts_o.clr_done = clr_done;
  assign sts_o.idle     = (state_q == V_IDLE);
  assign sts_o.done     = done_q;
  assign sts_o.chg      = chg_q;
  assign sts_o.up       = up_q;

endmodule

`default_nettype wire

### hw/rtl/rpc_tree.sv
// Fenwick tree over the peak flags: one memory of node sums, a point-add walk
// and a prefix-sum walk, one memory step per cycle. Depends on rpc_pkg.
`default_nettype none

module rpc_tree (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpc_pkg::tree_cmd_t cmd_i,
  output rpc_pkg::tree_sts_t sts_o
);
  import rpc_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_ADD  = 2'd1;
  localparam logic [1:0] T_PRE  = 2'd2;

  logic [CNT_W-1:0] mem [MAX_LENGTH];
  logic [CNT_W-1:0] rdata_q;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [CNT_W-1:0] mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;

  logic [1:0]       state_q, state_d;
  logic [CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_done;
  logic [KW-1:0]    k_q, k_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] sum_q, sum_d;

  logic [KW-1:0]    k_low;
  logic [KW-1:0]    k_next;
  logic [CNT_W-1:0] acc_sum;

  assign clr_done = (clr_cnt_q == CLR_W'(MAX_LENGTH));
  assign k_low    = k_q & (~k_q + KW'(1));
  assign k_next   = k_q + k_low;
  assign acc_sum  = acc_q + (pend_q ? rdata_q : CNT_W'(0));

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    k_d       = k_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    pend_d    = 1'b0;
    done_d    = 1'b0;
    sum_d     = sum_q;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;

    if (!clr_done) begin
      mem_we    = 1'b1;
      mem_wa    = clr_cnt_q[AW-1:0];
      clr_cnt_d = clr_cnt_q + CLR_W'(1);
    end

    case (state_q)
      T_IDLE: begin
        if (cmd_i.start) begin
          k_d   = cmd_i.k;
          neg_d = cmd_i.neg;
          acc_d = '0;
          if (cmd_i.add) begin
            mem_re  = 1'b1;
            mem_ra  = AW'(cmd_i.k - KW'(1));
            state_d = T_ADD;
          end else begin
            state_d = T_PRE;
          end
        end
      end
      T_ADD: begin
        mem_we = 1'b1;
        mem_wa = AW'(k_q - KW'(1));
        mem_wd = rdata_q + (neg_q ? {CNT_W{1'b1}} : CNT_W'(1));
        if (k_next <= KW'(MAX_LENGTH)) begin
          mem_re = 1'b1;
          mem_ra = AW'(k_next - KW'(1));
          k_d    = k_next;
        end else begin
          done_d  = 1'b1;
          state_d = T_IDLE;
        end
      end
      T_PRE: begin
        acc_d = acc_sum;
        if (k_q != '0) begin
          mem_re = 1'b1;
          mem_ra = AW'(k_q - KW'(1));
          k_d    = k_q & (k_q - KW'(1));
          pend_d = 1'b1;
        end else begin
          sum_d   = acc_sum;
          done_d  = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  assign sts_o.clr_done = clr_done;
  assign sts_o.idle     = (state_q == T_IDLE);
  assign sts_o.done     = done_q;
  assign sts_o.sum      = sum_q;

endmodule

`default_nettype wire

### hw/rtl/range_peak_counter_core.sv
// Range peak counter: sequencer over the value/flag store and the Fenwick tree.
// Query: 2 prefix walks of up to 10 tree reads each; update: 5-word window
// read, up to 3 write-backs and up to 3 point-add walks of up to 11 tree steps
// each; bad requests and short ranges are answered without a walk.
// One word in flight; the next is taken while a result waits. After reset both
// memories are zeroed. Uses rpc_pkg, the interfaces, submodules.
`default_nettype none

module range_peak_counter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rpc_pkg::LEN_W-1:0] cfg_wdata_i,
  rpc_req_if.sink                   req,
  rpc_rsp_if.source                 rsp
);
  import rpc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_Q1    = 3'd2;
  localparam logic [2:0] S_Q2    = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_FW    = 3'd5;
  localparam logic [2:0] S_FWW   = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  tree_cmd_t tree_cmd;
  tree_sts_t tree_sts;
  val_cmd_t  val_cmd;
  val_sts_t  val_sts;

  logic [2:0]       state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] sum_hi_q, sum_hi_d;
  logic [1:0]       o_q, o_d;
  logic [2:0]       chg_q, chg_d;
  logic [2:0]       up_q, up_d;
  logic [CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic             res_bad_q, res_bad_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             out_bad_q, out_bad_d;

  logic             accept;
  logic             q_bad;
  logic             q_short;
  logic             u_bad;

  rpc_values u_values (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (val_cmd),
    .sts_o  (val_sts)
  );

  rpc_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tree_cmd),
    .sts_o  (tree_sts)
  );

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign q_bad   = (LEN_W'(req.range_high) >= len_q) || (req.range_low > req.range_high);
  assign q_short = (req.range_high - req.range_low) < IDX_W'(2);
  assign u_bad   = (LEN_W'(req.update_index) >= len_q);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    sum_hi_d    = sum_hi_q;
    o_d         = o_q;
    chg_d       = chg_q;
    up_d        = up_q;
    res_cnt_d   = res_cnt_q;
    res_bad_d   = res_bad_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_cnt_d   = out_cnt_q;
    out_bad_d   = out_bad_q;

    tree_cmd       = '0;
    val_cmd        = '0;
    val_cmd.idx    = req.update_index;
    val_cmd.value  = req.update_value;
    val_cmd.len    = len_q;

    if (cfg_we_i) begin
      len_d = (cfg_wdata_i > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : cfg_wdata_i;
    end

    case (state_q)
      S_CLEAR: begin
        if (val_sts.clr_done && tree_sts.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_d = req.update_index;
          lo_d  = req.range_low;
          if (req.req_type == REQ_QUERY) begin
            if (q_bad) begin
              res_cnt_d = '0;
              res_bad_d = 1'b1;
              state_d   = S_RES;
            end else if (q_short) begin
              res_cnt_d = '0;
              res_bad_d = 1'b0;
              state_d   = S_RES;
            end else begin
              tree_cmd.start = 1'b1;
              tree_cmd.k     = KW'(req.range_high);
              state_d        = S_Q1;
            end
          end else begin
            if (u_bad) begin
              res_cnt_d = '0;
              res_bad_d = 1'b1;
              state_d   = S_RES;
            end else begin
              val_cmd.start = 1'b1;
              state_d       = S_UPD;
            end
          end
        end
      end
      S_Q1: begin
        if (tree_sts.done) begin
          sum_hi_d       = tree_sts.sum;
          tree_cmd.start = 1'b1;
          tree_cmd.k     = KW'(lo_q) + KW'(1);
          state_d        = S_Q2;
        end
      end
      S_Q2: begin
        if (tree_sts.done) begin
          res_cnt_d = sum_hi_q - tree_sts.sum;
          res_bad_d = 1'b0;
          state_d   = S_RES;
        end
      end
      S_UPD: begin
        if (val_sts.done) begin
          chg_d   = val_sts.chg;
          up_d    = val_sts.up;
          o_d     = '0;
          state_d = S_FW;
        end
      end
      S_FW: begin
        if (o_q == 2'd3) begin
          state_d = S_IDLE;
        end else if (chg_q[o_q]) begin
          tree_cmd.start = 1'b1;
          tree_cmd.add   = 1'b1;
          tree_cmd.neg   = !up_q[o_q];
          tree_cmd.k     = KW'(idx_q) + KW'(o_q);
          state_d        = S_FWW;
        end else begin
          o_d = o_q + 2'd1;
        end
      end
      S_FWW: begin
        if (tree_sts.done) begin
          o_d     = o_q + 2'd1;
          state_d = S_FW;
        end
      end
      S_RES: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = res_cnt_q;
          out_bad_d   = res_bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    lo_q      <= lo_d;
    sum_hi_q  <= sum_hi_d;
    o_q       <= o_d;
    chg_q     <= chg_d;
    up_q      <= up_d;
    res_cnt_q <= res_cnt_d;
    res_bad_q <= res_bad_d;
    out_cnt_q <= out_cnt_d;
    out_bad_q <= out_bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.peak_count  = out_cnt_q;
  assign rsp.bad_request = out_bad_q;

`ifndef SYNTHESIS
  a_tree_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_cmd.start |-> tree_sts.idle && tree_sts.clr_done)
    else $error("tree walk started while busy");

  a_val_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_cmd.start |-> val_sts.idle && val_sts.clr_done)
    else $error("value update started while busy");

  a_tree_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_sts.done |-> (state_q == S_Q1) || (state_q == S_Q2) || (state_q == S_FWW))
    else $error("tree done outside a wait state");

  a_val_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_sts.done |-> (state_q == S_UPD))
    else $error("value done outside update wait");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES) && out_valid_q && !rsp.ready |=> $stable(out_cnt_q)
      && $stable(out_bad_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
